### rtl/two_class_priority_scheduler_top_assert.svh
// Assertion macros for the two-class priority scheduler.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TWO_CLASS_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define TWO_CLASS_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tcps_pkg.sv
// Shared types and codes for the two-class priority scheduler.
// No dependencies.
package tcps_pkg;

	localparam int ID_W     = 16;
	localparam int AGE_W    = 8;
	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;
	localparam int WHERE_W  = 2;
	localparam int AHEAD_W  = 6;
	localparam int CNT_W    = 16;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SERVE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [WHERE_W-1:0] WHERE_NONE  = 2'd0;
	localparam logic [WHERE_W-1:0] WHERE_STACK = 2'd1;
	localparam logic [WHERE_W-1:0] WHERE_QUEUE = 2'd2;

	localparam logic CLASS_URGENT = 1'b0;
	localparam logic CLASS_NORMAL = 1'b1;

	localparam logic [AHEAD_W-1:0] AHEAD_MAX = 6'd63;
	localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [AGE_W-1:0] age;
	} slot_t;

endpackage

### rtl/two_class_priority_scheduler_top.sv
// Two-class priority scheduler: urgent LIFO stack and normal FIFO ring queue.
// Insert and no-op finish in S_EXEC, serve goes on through S_SERVE, and search scans in S_SEARCH.
// One item at a time; a search reads one stored entry per cycle from a memory port.
// done marks each result for one cycle and the receiver cannot stall it.
// Reset clears levels, pointers and served counters at once; the stores hold no reset.
// Depends on tcps_pkg and two_class_priority_scheduler_top_assert.svh.
`include "two_class_priority_scheduler_top_assert.svh"

module two_class_priority_scheduler_top #(
	parameter int CLASS_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [tcps_pkg::REQ_W-1:0]     req_type,
	input  logic [tcps_pkg::ID_W-1:0]      entry_id,
	input  logic [tcps_pkg::AGE_W-1:0]     entry_age,
	input  logic                           entry_class,
	output logic                           done,
	output logic [tcps_pkg::STATUS_W-1:0]  status,
	output logic [tcps_pkg::ID_W-1:0]      served_id,
	output logic [tcps_pkg::AGE_W-1:0]     served_age,
	output logic                           served_class,
	output logic [tcps_pkg::WHERE_W-1:0]   found_where,
	output logic [tcps_pkg::AHEAD_W-1:0]   ahead_count,
	output logic [tcps_pkg::CNT_W-1:0]     urgent_served,
	output logic [tcps_pkg::CNT_W-1:0]     normal_served
);

	localparam int IW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
	localparam int LW = $clog2(CLASS_DEPTH + 1);
	localparam int PW = $clog2(2 * CLASS_DEPTH + 1);
	localparam int QW = IW + 2;

	localparam logic [LW-1:0] LEVEL_FULL = LW'(CLASS_DEPTH);
	localparam logic [IW-1:0] IDX_LAST   = IW'(CLASS_DEPTH - 1);
	localparam logic [QW-1:0] Q_WRAP     = QW'(CLASS_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SERVE,
		S_SEARCH
	} state_t;

	state_t state_q;

	tcps_pkg::slot_t stk_mem [CLASS_DEPTH];
	tcps_pkg::slot_t que_mem [CLASS_DEPTH];
	tcps_pkg::slot_t stk_rdata_q;
	tcps_pkg::slot_t que_rdata_q;
	logic [IW-1:0] stk_raddr;
	logic [IW-1:0] que_raddr;
	logic          stk_we;
	logic          que_we;

	logic [tcps_pkg::REQ_W-1:0] req_q;
	logic [tcps_pkg::ID_W-1:0]  id_q;
	logic [tcps_pkg::AGE_W-1:0] age_q;
	logic                       cls_q;

	logic [LW-1:0] ulevel_q;
	logic [LW-1:0] nlevel_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [tcps_pkg::CNT_W-1:0] utotal_q;
	logic [tcps_pkg::CNT_W-1:0] ntotal_q;

	logic [PW-1:0] issue_q;
	logic          vld_s1;
	logic [PW-1:0] pos_s1;
	logic          cls_s1;

	logic                          done_q;
	logic [tcps_pkg::STATUS_W-1:0] status_q;
	tcps_pkg::slot_t               res_slot_q;
	logic                          res_cls_q;
	logic [tcps_pkg::WHERE_W-1:0]  where_q;
	logic [tcps_pkg::AHEAD_W-1:0]  ahead_q;

	logic [PW-1:0] total_pos;
	logic          issue_more;
	logic          issue_in_stack;
	logic [PW-1:0] stk_off;
	logic [PW-1:0] que_off;
	logic [QW-1:0] que_sum;
	logic [IW-1:0] que_search_addr;
	tcps_pkg::slot_t cmp_slot;
	logic          cmp_hit;
	logic [tcps_pkg::AHEAD_W-1:0] ahead_sat;

	always_comb begin
		total_pos      = PW'(ulevel_q) + PW'(nlevel_q);
		issue_more     = issue_q < total_pos;
		issue_in_stack = issue_q < PW'(ulevel_q);
		stk_off        = PW'(ulevel_q) - PW'(1) - issue_q;
		que_off        = issue_q - PW'(ulevel_q);
		que_sum        = QW'(head_q) + QW'(que_off);
		if (que_sum >= Q_WRAP) begin
			que_sum = que_sum - Q_WRAP;
		end
		que_search_addr = que_sum[IW-1:0];
		if (state_q == S_EXEC) begin
			stk_raddr = IW'(ulevel_q - LW'(1));
			que_raddr = head_q;
		end else begin
			stk_raddr = stk_off[IW-1:0];
			que_raddr = que_search_addr;
		end
		cmp_slot = cls_s1 ? que_rdata_q : stk_rdata_q;
		cmp_hit  = vld_s1 && (cmp_slot.id == id_q);
		if (32'(pos_s1) > 32'(tcps_pkg::AHEAD_MAX)) begin
			ahead_sat = tcps_pkg::AHEAD_MAX;
		end else begin
			ahead_sat = tcps_pkg::AHEAD_W'(pos_s1);
		end
		stk_we = (state_q == S_EXEC) && (req_q == tcps_pkg::REQ_INSERT) &&
			(cls_q == tcps_pkg::CLASS_URGENT) && (ulevel_q < LEVEL_FULL);
		que_we = (state_q == S_EXEC) && (req_q == tcps_pkg::REQ_INSERT) &&
			(cls_q == tcps_pkg::CLASS_NORMAL) && (nlevel_q < LEVEL_FULL);
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[ulevel_q[IW-1:0]] <= '{id: id_q, age: age_q};
		end
		stk_rdata_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk) begin
		if (que_we) begin
			que_mem[tail_q] <= '{id: id_q, age: age_q};
		end
		que_rdata_q <= que_mem[que_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= '0;
			id_q       <= '0;
			age_q      <= '0;
			cls_q      <= 1'b0;
			ulevel_q   <= '0;
			nlevel_q   <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			utotal_q   <= '0;
			ntotal_q   <= '0;
			issue_q    <= '0;
			vld_s1     <= 1'b0;
			pos_s1     <= '0;
			cls_s1     <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= tcps_pkg::ST_OK;
			res_slot_q <= '0;
			res_cls_q  <= 1'b0;
			where_q    <= tcps_pkg::WHERE_NONE;
			ahead_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q      <= req_type;
						id_q       <= entry_id;
						age_q      <= entry_age;
						cls_q      <= entry_class;
						status_q   <= tcps_pkg::ST_OK;
						res_slot_q <= '0;
						res_cls_q  <= 1'b0;
						where_q    <= tcps_pkg::WHERE_NONE;
						ahead_q    <= '0;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q)
						tcps_pkg::REQ_INSERT: begin
							if (cls_q == tcps_pkg::CLASS_URGENT) begin
								if (ulevel_q < LEVEL_FULL) begin
									ulevel_q <= ulevel_q + LW'(1);
								end else begin
									status_q <= tcps_pkg::ST_FULL;
								end
							end else begin
								if (nlevel_q < LEVEL_FULL) begin
									nlevel_q <= nlevel_q + LW'(1);
									tail_q   <= (tail_q == IDX_LAST) ? '0 : tail_q + IW'(1);
								end else begin
									status_q <= tcps_pkg::ST_FULL;
								end
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						tcps_pkg::REQ_SERVE: begin
							if (ulevel_q != '0) begin
								ulevel_q  <= ulevel_q - LW'(1);
								res_cls_q <= tcps_pkg::CLASS_URGENT;
								state_q   <= S_SERVE;
							end else if (nlevel_q != '0) begin
								nlevel_q  <= nlevel_q - LW'(1);
								head_q    <= (head_q == IDX_LAST) ? '0 : head_q + IW'(1);
								res_cls_q <= tcps_pkg::CLASS_NORMAL;
								state_q   <= S_SERVE;
							end else begin
								status_q <= tcps_pkg::ST_EMPTY;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						tcps_pkg::REQ_SEARCH: begin
							issue_q <= '0;
							vld_s1  <= 1'b0;
							state_q <= S_SEARCH;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SERVE: begin
					if (res_cls_q == tcps_pkg::CLASS_URGENT) begin
						res_slot_q <= stk_rdata_q;
						if (utotal_q != tcps_pkg::CNT_MAX) begin
							utotal_q <= utotal_q + tcps_pkg::CNT_W'(1);
						end
					end else begin
						res_slot_q <= que_rdata_q;
						if (ntotal_q != tcps_pkg::CNT_MAX) begin
							ntotal_q <= ntotal_q + tcps_pkg::CNT_W'(1);
						end
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SEARCH: begin
					if (cmp_hit) begin
						res_slot_q <= cmp_slot;
						res_cls_q  <= cls_s1;
						where_q    <= cls_s1 ? tcps_pkg::WHERE_QUEUE : tcps_pkg::WHERE_STACK;
						ahead_q    <= ahead_sat;
						vld_s1     <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (!issue_more && !vld_s1) begin
						status_q <= tcps_pkg::ST_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						vld_s1 <= issue_more;
						pos_s1 <= issue_q;
						cls_s1 <= !issue_in_stack;
						if (issue_more) begin
							issue_q <= issue_q + PW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign served_id     = res_slot_q.id;
	assign served_age    = res_slot_q.age;
	assign served_class  = res_cls_q;
	assign found_where   = where_q;
	assign ahead_count   = ahead_q;
	assign urgent_served = utotal_q;
	assign normal_served = ntotal_q;

	`TCPS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted transfer did not set busy")
	`TCPS_ASSERT_NOW(a_done_follows_busy, done, !busy && $past(busy), "result without a prior transfer")
	`TCPS_ASSERT_NOW(a_levels_bounded, 1'b1, (ulevel_q <= LEVEL_FULL) && (nlevel_q <= LEVEL_FULL), "class level beyond depth")
	`TCPS_ASSERT_NOW(a_hit_is_ok, done && (found_where != tcps_pkg::WHERE_NONE), status == tcps_pkg::ST_OK, "search hit with error status")
	`TCPS_ASSERT_NOW(a_scan_in_range, vld_s1, pos_s1 < total_pos, "scan position past live entries")

endmodule
